@@ rtl/core/vflfq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vflfq_pkg: shared types and constants of the vector field force query
// Opcodes, the tag that rides along the cell chains, the per-cell state of
// the square root and divider chains, and the packed result beat.
// ----------------------------------------------------------------------------
package vflfq_pkg;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_QUERY = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_PUT   = 5'b10000
  } state_e;

  localparam int unsigned ROOT_W   = 25;
  localparam int unsigned SREM_W   = ROOT_W + 2;
  localparam int unsigned RAD_W    = 2 * ROOT_W;
  localparam int unsigned SQ_STEPS = ROOT_W;
  localparam int unsigned DV_STEPS = 17;
  localparam int unsigned DV_REM_W = 16;
  localparam int unsigned R_W      = 16;

  localparam logic [R_W-1:0] RADIUS_RST = 16'd320;
  localparam logic [R_W-1:0] RADIUS_MIN = 16'd16;

  typedef struct packed {
    logic               valid;
    logic               hit;
    logic               best;
    logic signed [15:0] vel_x;
    logic signed [15:0] vel_y;
  } tag_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  typedef struct packed {
    logic [DV_REM_W-1:0] rem;
    logic [DV_STEPS-1:0] num;
    logic [DV_STEPS-1:0] quo;
  } dv_t;

  typedef struct packed {
    logic        load_rejected;
    logic        table_empty;
    logic [16:0] nearest_dist;
    logic [5:0]  nearest_index;
    logic [6:0]  hit_count;
    logic [15:0] force_y;
    logic [15:0] force_x;
  } res_t;

endpackage

@@ rtl/core/vflfq_sqrt_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vflfq_sqrt_cell: one digit step of the integer square root chain
// Takes two radicand bits, tries the next root bit and hands the partial
// root, remainder and tag to the next cell every cycle.
// ----------------------------------------------------------------------------
module vflfq_sqrt_cell import vflfq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  sq_t  sq_i,
  input  tag_t tag_i,
  output sq_t  sq_o,
  output tag_t tag_o
);

  logic [SREM_W-1:0] rem_sh;
  logic [SREM_W-1:0] trial;
  logic              ge;
  sq_t               sq_d;
  sq_t               sq_q;
  tag_t              tag_q;

  always_comb begin
    rem_sh      = {sq_i.rem[SREM_W-3:0], sq_i.rad[RAD_W-1 -: 2]};
    trial       = {sq_i.root, 2'b01};
    ge          = rem_sh >= trial;
    sq_d.rad    = {sq_i.rad[RAD_W-3:0], 2'b00};
    sq_d.rem    = ge ? (rem_sh - trial) : rem_sh;
    sq_d.root   = {sq_i.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    sq_q <= sq_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  assign sq_o  = sq_q;
  assign tag_o = tag_q;

endmodule

@@ rtl/core/vflfq_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vflfq_div_cell: one quotient bit of the restoring divider chain
// Brings down one numerator bit, subtracts the divisor when it fits and
// hands remainder, quotient and tag to the next cell every cycle.
// ----------------------------------------------------------------------------
module vflfq_div_cell import vflfq_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [R_W-1:0] divisor_i,
  input  dv_t            dv_i,
  input  tag_t           tag_i,
  output dv_t            dv_o,
  output tag_t           tag_o
);

  logic [DV_REM_W:0] t;
  logic [DV_REM_W:0] sub;
  logic              ge;
  dv_t               dv_d;
  dv_t               dv_q;
  tag_t              tag_q;

  always_comb begin
    t        = {dv_i.rem, dv_i.num[DV_STEPS-1]};
    sub      = t - {1'b0, divisor_i};
    ge       = t >= {1'b0, divisor_i};
    dv_d.rem = ge ? sub[DV_REM_W-1:0] : t[DV_REM_W-1:0];
    dv_d.num = {dv_i.num[DV_STEPS-2:0], 1'b0};
    dv_d.quo = {dv_i.quo[DV_STEPS-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    dv_q <= dv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  assign dv_o  = dv_q;
  assign tag_o = tag_q;

endmodule

@@ rtl/core/vector_field_local_force_query.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_field_local_force_query: radius weighted vector field lookup
// Holds a table of current vectors and answers queries with the weighted
// mean velocity inside the radius and the nearest entry.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis beats carry an opcode in tuser (load, query, clear) and position
//   and velocity in tdata. Every input beat yields exactly one m_axis beat.
//   The cfg channel writes the radius (Q12.4), saturated to at least 1 m; it
//   is always ready and must only be written while the block is idle.
//   Load, clear and unused opcodes go from the idle state through the put
//   state to the output register; the put state waits on a stalled receiver.
//   A query walks the table one entry per cycle through the memory read
//   port, then through the squaring and summing stages, a 25 cell square
//   root chain, a 17 cell divider chain and four multiply/accumulate stages,
//   then a bit serial mean divider of 18 + log2(MAX_ENTRIES) steps that is
//   skipped when nothing is in range; the result then passes through the put
//   state into the output register.
//   One item is in work at a time; the next one is taken while the result
//   still waits in the output register.
//   Reset empties the table and sets the radius to 20 m. A stalled receiver
//   holds the result beat; the block finishes the next item and then waits.
// ----------------------------------------------------------------------------
module vector_field_local_force_query import vflfq_pkg::*; #(
  parameter int unsigned MAX_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,    // radius
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // pos_x, pos_y, vel_x, vel_y
  input  logic [1:0]  s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // force_x, force_y, hit_count, nearest_index,
                                     // nearest_dist, table_empty, load_rejected
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned ACC_W = 34 + IDX_W;
  localparam int unsigned MAG_W = ACC_W - 16;
  localparam int unsigned DC_W  = $clog2(MAG_W + 1);

  state_e           state_q;
  logic [CNT_W-1:0] count_q;
  logic [R_W-1:0]   radius_q;
  logic [31:0]      r2_q;
  logic [R_W-1:0]   rsat;
  logic             full;
  op_e              op;

  logic [63:0]      mem [MAX_ENTRIES];
  logic [63:0]      e_q;
  logic [IDX_W-1:0] rd_addr_q;

  // entry pipeline ahead of the chains
  logic             v1_q, v2_q, v3_q, inj_q;
  logic             last1_q, last2_q, last3_q;
  logic [IDX_W-1:0] idx1_q, idx2_q, idx3_q;
  logic signed [15:0] px_q, py_q;
  logic signed [16:0] dx, dy;
  logic signed [33:0] dxe, dye;
  logic [33:0]      sqx_q, sqy_q, d2_q;
  logic [15:0]      vx2_q, vy2_q, vx3_q, vy3_q;
  logic [33:0]      best_q;
  logic [IDX_W-1:0] bidx_q;
  logic [16:0]      near_dist_q;

  // cell chains
  sq_t              sq_in;
  tag_t             sqt_in;
  wire sq_t         sq_c  [SQ_STEPS+1];
  wire tag_t        sqt_c [SQ_STEPS+1];
  dv_t              dv_in;
  wire dv_t         dv_c  [DV_STEPS+1];
  wire tag_t        dvt_c [DV_STEPS+1];
  logic [23:0]      diff;

  // weight and accumulate stages
  logic [33:0]        uu_q;
  logic [15:0]        w_q;
  logic signed [32:0] pwx_q, pwy_q;
  logic signed [32:0] vxe, vye, we;
  tag_t               tag_m1_q, tag_m2_q, tag_m3_q;
  logic signed [ACC_W-1:0] sx_q, sy_q;
  logic [CNT_W-1:0]   hits_q;

  // mean divider
  logic [ACC_W-1:0] absx, absy;
  logic [MAG_W-1:0] qx_q, qy_q;
  logic [CNT_W-1:0] rx_q, ry_q;
  logic             negx_q, negy_q;
  logic [DC_W-1:0]  dcnt_q;
  logic [CNT_W:0]   tx, ty, subx, suby;
  logic             gex, gey;

  res_t             res_q;
  res_t             out_q;
  logic             m_valid_q;

  assign op            = op_e'(s_axis_tuser);
  assign rsat          = (cfg_data_i < RADIUS_MIN) ? RADIUS_MIN : cfg_data_i;
  assign full          = count_q >= CNT_W'(MAX_ENTRIES);
  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_q;

  always_comb begin
    dx  = 17'(px_q) - 17'($signed(e_q[15:0]));
    dy  = 17'(py_q) - 17'($signed(e_q[31:16]));
    dxe = 34'(dx);
    dye = 34'(dy);
    vxe = 33'(tag_m2_q.vel_x);
    vye = 33'(tag_m2_q.vel_y);
    we  = $signed({17'd0, w_q});
  end

  // chain inputs: entries first, then one token carrying the best distance
  always_comb begin
    sq_in        = '0;
    sqt_in       = '0;
    if (v3_q) begin
      sq_in.rad    = {d2_q, 16'd0};
      sqt_in.valid = 1'b1;
      sqt_in.hit   = d2_q < {2'b00, r2_q};
      sqt_in.vel_x = $signed(vx3_q);
      sqt_in.vel_y = $signed(vy3_q);
    end else if (inj_q) begin
      sq_in.rad    = {best_q, 16'd0};
      sqt_in.best  = 1'b1;
    end
  end

  assign sq_c[0]  = sq_in;
  assign sqt_c[0] = sqt_in;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    vflfq_sqrt_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .sq_i   (sq_c[g]),
      .tag_i  (sqt_c[g]),
      .sq_o   (sq_c[g+1]),
      .tag_o  (sqt_c[g+1])
    );
  end

  // u = (rq - dq) * 2^8 / r with rq = r * 2^8
  always_comb begin
    diff      = {radius_q, 8'd0} - sq_c[SQ_STEPS].root[23:0];
    dv_in.rem = {1'b0, diff[23:9]};
    dv_in.num = {diff[8:0], 8'd0};
    dv_in.quo = '0;
  end

  assign dv_c[0]  = dv_in;
  assign dvt_c[0] = sqt_c[SQ_STEPS];

  for (genvar g = 0; g < DV_STEPS; g++) begin : g_div
    vflfq_div_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .divisor_i (radius_q),
      .dv_i      (dv_c[g]),
      .tag_i     (dvt_c[g]),
      .dv_o      (dv_c[g+1]),
      .tag_o     (dvt_c[g+1])
    );
  end

  always_comb begin
    absx = sx_q[ACC_W-1] ? ACC_W'(-sx_q) : ACC_W'(sx_q);
    absy = sy_q[ACC_W-1] ? ACC_W'(-sy_q) : ACC_W'(sy_q);
    tx   = {rx_q, qx_q[MAG_W-1]};
    ty   = {ry_q, qy_q[MAG_W-1]};
    subx = tx - {1'b0, hits_q};
    suby = ty - {1'b0, hits_q};
    gex  = tx >= {1'b0, hits_q};
    gey  = ty >= {1'b0, hits_q};
  end

  // table memory and datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid && op == OP_LOAD && !full) begin
      mem[count_q[IDX_W-1:0]] <= s_axis_tdata;
    end
    e_q <= mem[rd_addr_q];

    sqx_q <= unsigned'(dxe * dxe);
    sqy_q <= unsigned'(dye * dye);
    vx2_q <= e_q[47:32];
    vy2_q <= e_q[63:48];
    idx2_q <= idx1_q;
    d2_q  <= sqx_q + sqy_q;
    vx3_q <= vx2_q;
    vy3_q <= vy2_q;
    idx3_q <= idx2_q;

    // first index wins ties
    if (v3_q && (idx3_q == '0 || d2_q < best_q)) begin
      best_q <= d2_q;
      bidx_q <= idx3_q;
    end
    if (sqt_c[SQ_STEPS].best) begin
      near_dist_q <= sq_c[SQ_STEPS].root[ROOT_W-1:8];
    end

    uu_q  <= 34'(dv_c[DV_STEPS].quo) * 34'(dv_c[DV_STEPS].quo);
    w_q   <= (uu_q[33:16] > 18'd65535) ? 16'hFFFF : uu_q[31:16];
    pwx_q <= vxe * we;
    pwy_q <= vye * we;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      radius_q  <= RADIUS_RST;
      r2_q      <= 32'(RADIUS_RST) * 32'(RADIUS_RST);
      m_valid_q <= 1'b0;
      out_q     <= '0;
      res_q     <= '0;
      rd_addr_q <= '0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      v3_q      <= 1'b0;
      inj_q     <= 1'b0;
      last1_q   <= 1'b0;
      last2_q   <= 1'b0;
      last3_q   <= 1'b0;
      idx1_q    <= '0;
      px_q      <= '0;
      py_q      <= '0;
      tag_m1_q  <= '0;
      tag_m2_q  <= '0;
      tag_m3_q  <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      hits_q    <= '0;
      qx_q      <= '0;
      qy_q      <= '0;
      rx_q      <= '0;
      ry_q      <= '0;
      negx_q    <= 1'b0;
      negy_q    <= 1'b0;
      dcnt_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        radius_q <= rsat;
        r2_q     <= 32'(rsat) * 32'(rsat);
      end
      if (m_valid_q && m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      v1_q     <= 1'b0;
      v2_q     <= v1_q;
      v3_q     <= v2_q;
      last2_q  <= last1_q;
      last3_q  <= last2_q;
      inj_q    <= v3_q && last3_q;
      tag_m1_q <= dvt_c[DV_STEPS];
      tag_m2_q <= tag_m1_q;
      tag_m3_q <= tag_m2_q;

      if (tag_m3_q.valid && tag_m3_q.hit) begin
        sx_q   <= sx_q + ACC_W'(pwx_q);
        sy_q   <= sy_q + ACC_W'(pwy_q);
        hits_q <= hits_q + CNT_W'(1);
      end

      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            res_q   <= '0;
            state_q <= ST_PUT;
            unique case (op)
              OP_LOAD: begin
                if (full) begin
                  res_q.load_rejected <= 1'b1;
                end else begin
                  count_q <= count_q + CNT_W'(1);
                end
              end
              OP_QUERY: begin
                if (count_q == '0) begin
                  res_q.table_empty <= 1'b1;
                end else begin
                  px_q      <= $signed(s_axis_tdata[15:0]);
                  py_q      <= $signed(s_axis_tdata[31:16]);
                  sx_q      <= '0;
                  sy_q      <= '0;
                  hits_q    <= '0;
                  rd_addr_q <= '0;
                  state_q   <= ST_SCAN;
                end
              end
              OP_CLEAR: begin
                count_q           <= '0;
                res_q.table_empty <= 1'b1;
              end
              default: begin
                res_q.table_empty <= count_q == '0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          v1_q    <= 1'b1;
          idx1_q  <= rd_addr_q;
          last1_q <= (CNT_W'(rd_addr_q) + CNT_W'(1)) == count_q;
          if ((CNT_W'(rd_addr_q) + CNT_W'(1)) == count_q) begin
            state_q <= ST_DRAIN;
          end else begin
            rd_addr_q <= rd_addr_q + IDX_W'(1);
          end
        end
        ST_DRAIN: begin
          // best token trails every entry: all sums are final when it arrives
          if (tag_m3_q.best) begin
            res_q.hit_count     <= 7'(hits_q);
            res_q.nearest_index <= 6'(bidx_q);
            res_q.nearest_dist  <= near_dist_q;
            if (hits_q == '0) begin
              state_q <= ST_PUT;
            end else begin
              qx_q    <= absx[ACC_W-1:16];
              qy_q    <= absy[ACC_W-1:16];
              negx_q  <= sx_q[ACC_W-1];
              negy_q  <= sy_q[ACC_W-1];
              rx_q    <= '0;
              ry_q    <= '0;
              dcnt_q  <= '0;
              state_q <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (dcnt_q == DC_W'(MAG_W)) begin
            res_q.force_x <= negx_q ? 16'(-qx_q) : 16'(qx_q);
            res_q.force_y <= negy_q ? 16'(-qy_q) : 16'(qy_q);
            state_q       <= ST_PUT;
          end else begin
            rx_q   <= gex ? subx[CNT_W-1:0] : tx[CNT_W-1:0];
            ry_q   <= gey ? suby[CNT_W-1:0] : ty[CNT_W-1:0];
            qx_q   <= {qx_q[MAG_W-2:0], gex};
            qy_q   <= {qy_q[MAG_W-2:0], gey};
            dcnt_q <= dcnt_q + DC_W'(1);
          end
        end
        ST_PUT: begin
          if (!m_valid_q || m_axis_tready) begin
            out_q     <= res_q;
            m_valid_q <= 1'b1;
            state_q   <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
